[sv/enac_pkg.sv]
// Shared types and constants of the edge-avoiding navigation controller.
package enac_pkg;

	localparam int TIME_BITS = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CFG_LEFT_GAIN = 2'd0;
	localparam logic [1:0] CFG_RIGHT_GAIN = 2'd1;
	localparam logic [1:0] CFG_SECOND_TICKS = 2'd2;

	localparam logic [7:0] LEFT_GAIN_RESET = 8'd200;
	localparam logic [7:0] RIGHT_GAIN_RESET = 8'd190;
	localparam logic [15:0] SECOND_TICKS_RESET = 16'd7812;

	localparam logic [31:0] LCG_MUL = 32'd587381;
	localparam logic [31:0] LCG_INC = 32'd592693;
	localparam logic [31:0] SEED_RESET = 32'h0000_1337;
	localparam int LCG_PICK_BIT = 8;

	localparam logic [7:0] POWER_PIVOT = 8'd200;
	localparam logic [7:0] POWER_MAX = 8'd255;

	// x / 3 == (x * 171) >> 9 for every 8-bit x
	localparam logic [16:0] DIV3_MUL = 17'd171;
	localparam int DIV3_SHIFT = 9;

	typedef enum logic [2:0] {
		MODE_FWD    = 3'd0,
		MODE_BACK_L = 3'd1,
		MODE_BACK_R = 3'd2,
		MODE_LEFT   = 3'd3,
		MODE_RIGHT  = 3'd4,
		MODE_TURN_L = 3'd5,
		MODE_TURN_R = 3'd6
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] power;
	} queue_entry_t;

	typedef struct packed {
		mode_t      mode;
		logic       lrev;
		logic [7:0] lmag;
		logic       rrev;
		logic [7:0] rmag;
	} drive_t;

endpackage

[sv/enac_front.sv]
// Front end: accepts ticks, runs the mode machine, power ramp and LCG.
module enac_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [31:0]           time_now,
	input  logic                  left_edge,
	input  logic                  right_edge,
	input  logic [15:0]           second_ticks,
	output enac_pkg::queue_entry_t push_entry
);
	import enac_pkg::*;

	mode_t                mode_q;
	logic [7:0]           power_q;
	logic [TIME_BITS-1:0] entry_q;
	logic [31:0]          seed_q;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] tin;
	logic [31:0]          seed_nxt;
	logic                 seed_adv;
	mode_t                mode_nxt;
	logic [7:0]           pow_pre;
	logic [7:0]           pow_nxt;
	logic                 back_done;
	logic                 pivot_done;

	always_comb begin
		now_t = TIME_BITS'(time_now);
		tin = now_t - entry_q;
		seed_nxt = seed_q * LCG_MUL + LCG_INC;
		back_done = tin > TIME_BITS'(second_ticks);
		pivot_done = tin > TIME_BITS'(second_ticks >> 1);
		mode_nxt = mode_q;
		pow_pre = power_q;
		seed_adv = 1'b0;
		unique case (mode_q)
			MODE_BACK_R: begin
				if (back_done) begin
					mode_nxt = MODE_RIGHT;
					pow_pre = POWER_PIVOT;
				end
			end
			MODE_BACK_L: begin
				if (back_done) begin
					mode_nxt = MODE_LEFT;
					pow_pre = POWER_PIVOT;
				end
			end
			MODE_LEFT, MODE_RIGHT: begin
				if (pivot_done) begin
					mode_nxt = MODE_FWD;
					pow_pre = '0;
				end
			end
			default: begin
				priority if (left_edge && right_edge) begin
					seed_adv = 1'b1;
					mode_nxt = seed_nxt[LCG_PICK_BIT] ? MODE_BACK_L : MODE_BACK_R;
					pow_pre = '0;
				end else if (left_edge) begin
					mode_nxt = MODE_TURN_R;
				end else if (right_edge) begin
					mode_nxt = MODE_TURN_L;
				end else begin
					mode_nxt = MODE_FWD;
				end
			end
		endcase
		pow_nxt = (pow_pre == POWER_MAX) ? POWER_MAX : pow_pre + 8'd1;
		push_entry.mode = mode_nxt;
		push_entry.power = pow_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FWD;
			power_q <= '0;
			entry_q <= '0;
			seed_q <= SEED_RESET;
		end else if (accept) begin
			mode_q <= mode_nxt;
			power_q <= pow_nxt;
			if (mode_nxt != mode_q)
				entry_q <= now_t;
			if (seed_adv)
				seed_q <= seed_nxt;
		end
	end

	a_entry_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode_nxt != mode_q) |=> entry_q == $past(now_t))
		else $error("entry time not taken on mode change");

	a_seed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !(left_edge && right_edge) |=> $stable(seed_q))
		else $error("LCG advanced without a double edge");

endmodule

[sv/enac_queue.sv]
// Short queue of classified ticks between front and back end.
module enac_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  enac_pkg::queue_entry_t push_entry,
	input  logic                   pop,
	output enac_pkg::queue_entry_t pop_entry,
	output logic                   full,
	output logic                   empty
);
	import enac_pkg::*;

	queue_entry_t      mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue overflow or underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

[sv/enac_back.sv]
// Back end: motor drive from mode and power, gain scaling, output register.
module enac_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  enac_pkg::queue_entry_t q_entry,
	output logic                   q_pop,
	input  logic [7:0]             left_gain,
	input  logic [7:0]             right_gain,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             mode,
	output logic                   left_reverse,
	output logic [7:0]             left_duty,
	output logic                   right_reverse,
	output logic [7:0]             right_duty
);
	import enac_pkg::*;

	logic        valid_s1;
	drive_t      drive_s1;
	drive_t      drive_c;
	logic        adv_s1;
	logic        adv_out;
	logic [16:0] prod3;
	logic [7:0]  third;
	logic [7:0]  half;
	logic [7:0]  p;
	logic [15:0] lprod;
	logic [15:0] rprod;

	assign adv_out = !out_valid || out_ready;
	assign adv_s1 = !valid_s1 || adv_out;
	assign q_pop = !q_empty && adv_s1;

	always_comb begin
		p = q_entry.power;
		prod3 = 17'(p) * DIV3_MUL;
		third = prod3[DIV3_SHIFT +: 8];
		half = p >> 1;
		drive_c.mode = q_entry.mode;
		drive_c.lrev = 1'b0;
		drive_c.lmag = p;
		drive_c.rrev = 1'b0;
		drive_c.rmag = p;
		unique case (q_entry.mode)
			MODE_TURN_L: drive_c.lmag = half;
			MODE_TURN_R: drive_c.rmag = half;
			MODE_BACK_L, MODE_BACK_R: begin
				drive_c.lrev = third != '0;
				drive_c.lmag = third;
				drive_c.rrev = third != '0;
				drive_c.rmag = third;
			end
			MODE_RIGHT: begin
				drive_c.lmag = half;
				drive_c.rrev = third != '0;
				drive_c.rmag = third;
			end
			MODE_LEFT: begin
				drive_c.lrev = third != '0;
				drive_c.lmag = third;
				drive_c.rmag = half;
			end
			default: ;
		endcase
		lprod = 16'(drive_s1.lmag) * 16'(left_gain);
		rprod = 16'(drive_s1.rmag) * 16'(right_gain);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= !q_empty;
			if (adv_out)
				out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			drive_s1 <= drive_c;
		if (adv_out && valid_s1) begin
			mode <= drive_s1.mode;
			left_reverse <= drive_s1.lrev;
			left_duty <= lprod[15:8];
			right_reverse <= drive_s1.rrev;
			right_duty <= rprod[15:8];
		end
	end

	a_back_sym: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (drive_s1.mode == MODE_BACK_L || drive_s1.mode == MODE_BACK_R)
		|-> drive_s1.lrev == drive_s1.rrev && drive_s1.lmag == drive_s1.rmag)
		else $error("backing drive not symmetric");

	a_fwd_no_rev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode == MODE_FWD) |-> !left_reverse && !right_reverse)
		else $error("reverse drive in forward mode");

endmodule

[sv/edge_avoid_nav_controller_top.sv]
// Top level of the edge-avoiding navigation controller.
// Usage:
//  - Input channel (in_valid/in_ready): one transfer per navigation tick with
//    time_now, left_edge and right_edge. Every accepted tick yields exactly
//    one result on the output channel, in order.
//  - Output channel (out_valid/out_ready): mode, motor direction bits and
//    gain-scaled duties after that tick.
//  - Configuration: cfg_we writes cfg_data into register cfg_index
//    (0 left_gain, 1 right_gain, 2 second_ticks); index 3 is ignored.
//    Write only while no tick is in flight.
//  - Path: an accepted tick is written into the queue, then passes the drive
//    stage register and the output register, in that order.
//  - Throughput: one tick per cycle unless stalled; the front updates its
//    state per tick and the back end is two stages behind a two-entry queue.
//  - Stall: when out_ready is low the pipeline and queue fill; in_ready drops
//    once the queue is full, after up to four ticks are held internally.
//  - Reset: mode forward, power zero, entry time zero, LCG seed 0x1337,
//    gains 200/190, second_ticks 7812; no results pending.
module edge_avoid_nav_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] time_now,
	input  logic        left_edge,
	input  logic        right_edge,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  mode,
	output logic        left_reverse,
	output logic [7:0]  left_duty,
	output logic        right_reverse,
	output logic [7:0]  right_duty,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import enac_pkg::*;

	logic [7:0]   left_gain_q;
	logic [7:0]   right_gain_q;
	logic [15:0]  second_ticks_q;
	logic         accept;
	logic         q_full;
	logic         q_empty;
	logic         q_pop;
	queue_entry_t push_entry;
	queue_entry_t pop_entry;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_gain_q <= LEFT_GAIN_RESET;
			right_gain_q <= RIGHT_GAIN_RESET;
			second_ticks_q <= SECOND_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEFT_GAIN:    left_gain_q <= cfg_data[7:0];
				CFG_RIGHT_GAIN:   right_gain_q <= cfg_data[7:0];
				CFG_SECOND_TICKS: second_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	enac_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.time_now     (time_now),
		.left_edge    (left_edge),
		.right_edge   (right_edge),
		.second_ticks (second_ticks_q),
		.push_entry   (push_entry)
	);

	enac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_entry (push_entry),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	enac_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_entry       (pop_entry),
		.q_pop         (q_pop),
		.left_gain     (left_gain_q),
		.right_gain    (right_gain_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mode          (mode),
		.left_reverse  (left_reverse),
		.left_duty     (left_duty),
		.right_reverse (right_reverse),
		.right_duty    (right_duty)
	);

endmodule
